[design/sha_pkg.sv]
// Shared types, constants and round tables for the SHA-256 hasher.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    // Depth of the word queue between byte packer and compression core.
    localparam int unsigned QUEUE_DEPTH = 4;

    // One 32-bit message word on its way to the core.
    typedef struct packed {
        logic [31:0] word;
        logic        fin;   // last word of the final block of a message
        logic        err;   // length overflowed: no word, report an error
    } q_entry_t;

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] r;
        unique case (idx)
            3'd0: r = 32'h6A09E667;
            3'd1: r = 32'hBB67AE85;
            3'd2: r = 32'h3C6EF372;
            3'd3: r = 32'hA54FF53A;
            3'd4: r = 32'h510E527F;
            3'd5: r = 32'h9B05688C;
            3'd6: r = 32'h1F83D9AB;
            3'd7: r = 32'h5BE0CD19;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] r;
        unique case (idx)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[design/sha_fifo.sv]
// Small word queue between the byte packer and the compression core.
`timescale 1ns / 1ps
`default_nettype none
module sha_fifo #(
    parameter int unsigned DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  sha_pkg::q_entry_t      din,
    output logic                   full,
    input  wire logic              pop,
    output sha_pkg::q_entry_t      dout,
    output logic                   not_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    sha_pkg::q_entry_t  mem_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [AW:0]        count_reg, count_next;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign dout      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end
endmodule
`default_nettype wire

[design/sha_front.sv]
// Byte packer: length count, overflow detection, padding and word assembly.
`timescale 1ns / 1ps
`default_nettype none
module sha_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_kind,
    input  wire logic [7:0]    s_data_byte,
    output logic               q_push,
    output sha_pkg::q_entry_t  q_data,
    input  wire logic          q_full
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MARK = 2'd1;
    localparam logic [1:0] PH_ZERO = 2'd2;
    localparam logic [1:0] PH_LEN  = 2'd3;
    localparam logic       KIND_BYTE = 1'b0;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [7:0] PAD_MARK = 8'h80;

    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic        ovf_reg, ovf_next;
    logic [23:0] word_reg, word_next;

    logic        byte_go;
    logic [7:0]  byte_val;
    logic        byte_fin;
    logic [64:0] len_sum;
    logic [63:0] len_sh;
    logic [5:0]  fill_inc;

    assign s_ready  = (phase_reg == PH_IDLE) && !q_full;
    assign len_sum  = {1'b0, len_reg} + 65'd8;
    assign len_sh   = len_reg >> {3'd7 - fill_reg[2:0], 3'b000};
    assign fill_inc = fill_reg + 6'd1;

    always_comb begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        word_next  = word_reg;
        byte_go    = 1'b0;
        byte_val   = 8'h00;
        byte_fin   = 1'b0;
        q_push     = 1'b0;
        q_data     = '{word: 32'h0, fin: 1'b0, err: 1'b0};

        unique case (phase_reg)
            PH_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_kind == KIND_BYTE) begin
                        if (!ovf_reg) begin
                            len_next = len_sum[63:0];
                            if (len_sum[64]) begin
                                // block can never complete: drop the byte
                                ovf_next = 1'b1;
                            end else begin
                                byte_go  = 1'b1;
                                byte_val = s_data_byte;
                            end
                        end
                    end else if (ovf_reg) begin
                        q_push     = 1'b1;
                        q_data.err = 1'b1;
                        fill_next  = '0;
                        len_next   = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        phase_next = PH_MARK;
                    end
                end
            end
            PH_MARK: begin
                if (!q_full) begin
                    byte_go    = 1'b1;
                    byte_val   = PAD_MARK;
                    phase_next = (fill_inc == LEN_POS) ? PH_LEN : PH_ZERO;
                end
            end
            PH_ZERO: begin
                if (!q_full) begin
                    byte_go = 1'b1;
                    if (fill_inc == LEN_POS) begin
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                if (!q_full) begin
                    byte_go  = 1'b1;
                    byte_val = len_sh[7:0];
                    if (fill_reg == 6'd63) begin
                        byte_fin   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: phase_next = PH_IDLE;
        endcase

        if (byte_go) begin
            word_next = {word_reg[15:0], byte_val};
            fill_next = fill_inc;
            if (fill_reg[1:0] == 2'd3) begin
                q_push      = 1'b1;
                q_data.word = {word_reg, byte_val};
                q_data.fin  = byte_fin;
            end
            if (byte_fin) begin
                len_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end
endmodule
`default_nettype wire

[design/sha_core.sv]
// Compression core: one round per cycle while message words are available, chaining update and digest output.
`timescale 1ns / 1ps
`default_nettype none
module sha_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  sha_pkg::q_entry_t  q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_status,
    output logic [2:0]         m_word_index,
    output logic [31:0]        m_digest_word,
    output logic               m_last
);
    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_UPD = 2'd1;
    localparam logic [1:0] ST_DIG = 2'd2;
    localparam logic [1:0] ST_ERR = 2'd3;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [1:0]  state_reg, state_next;
    logic [6:0]  t_reg, t_next;
    logic [2:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];

    logic        out_free;
    logic        load_out;
    logic        out_status, out_last;
    logic [2:0]  out_idx;
    logic [31:0] out_word;

    logic        step;
    logic [31:0] wt, ws0, ws1, wsch;
    logic [31:0] big0, big1, ch, maj, t1, t2;

    assign out_free = !m_valid || m_ready;

    // message schedule from the 16-word window
    assign ws0  = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
    assign ws1  = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
    assign wsch = ws1 + win_reg[9] + ws0 + win_reg[0];
    assign wt   = (t_reg[6:4] == 3'd0) ? q_data.word : wsch;

    assign big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + sha_pkg::round_k(t_reg[5:0]) + wt;
    assign big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2   = big0 + maj;

    always_comb begin
        state_next = state_reg;
        t_next     = t_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        v_next     = v_reg;
        h_next     = h_reg;
        win_next   = win_reg;
        q_pop      = 1'b0;
        step       = 1'b0;
        load_out   = 1'b0;
        out_status = 1'b0;
        out_idx    = idx_reg;
        out_word   = h_reg[idx_reg];
        out_last   = 1'b0;

        unique case (state_reg)
            ST_RUN: begin
                if (t_reg[6]) begin
                    state_next = ST_UPD;
                end else if (t_reg[5:4] != 2'd0) begin
                    step = 1'b1;
                end else if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_data.err) begin
                        state_next = ST_ERR;
                    end else begin
                        step = 1'b1;
                        if (t_reg[3:0] == 4'd15) begin
                            fin_next = q_data.fin;
                        end
                    end
                end
            end
            ST_UPD: begin
                for (int i = 0; i < 8; i++) begin
                    h_next[i] = h_reg[i] + v_reg[i];
                    v_next[i] = h_reg[i] + v_reg[i];
                end
                t_next     = '0;
                idx_next   = '0;
                state_next = fin_reg ? ST_DIG : ST_RUN;
            end
            ST_DIG: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_last = (idx_reg == 3'd7);
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        for (int i = 0; i < 8; i++) begin
                            h_next[i] = sha_pkg::init_word(3'(i));
                            v_next[i] = sha_pkg::init_word(3'(i));
                        end
                        fin_next   = 1'b0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    out_status = 1'b1;
                    out_idx    = 3'd0;
                    out_word   = 32'h0;
                    out_last   = 1'b1;
                    for (int i = 0; i < 8; i++) begin
                        h_next[i] = sha_pkg::init_word(3'(i));
                        v_next[i] = sha_pkg::init_word(3'(i));
                    end
                    t_next     = '0;
                    fin_next   = 1'b0;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase

        if (step) begin
            for (int i = 0; i < 15; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[15] = wt;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            t_next    = t_reg + 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            t_reg     <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            m_valid   <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= sha_pkg::init_word(3'(i));
                h_reg[i] <= sha_pkg::init_word(3'(i));
            end
        end else begin
            state_reg <= state_next;
            t_reg     <= t_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            v_reg     <= v_next;
            h_reg     <= h_next;
            if (load_out) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        if (load_out) begin
            m_status      <= out_status;
            m_word_index  <= out_idx;
            m_digest_word <= out_word;
            m_last        <= out_last;
        end
    end
endmodule
`default_nettype wire

[design/sha256_message_hasher.sv]
// SHA-256 message hasher top level: byte packer, word queue, compression core.
//
// Message bytes are taken one per cycle while the word queue has room and
// no padding is under way; a finish item starts the padding, which the
// packer generates one byte per cycle while the queue has room (9 to 72
// bytes), then the core returns eight digest words, index 0 first, last set
// on index 7. The core runs one round per clock, the first 16 rounds
// waiting for words from the queue; each 64-byte block takes 64 rounds, a
// turnaround state and the chaining add. The queue lets the packer take new
// bytes while the core works on a block, and the input stalls while the
// queue is full. If the 64-bit bit count overflows, later bytes are
// dropped and the finish item returns one result with status 1 and last 1.
// After every finish the hasher starts afresh with the initial hash values.
`timescale 1ns / 1ps
`default_nettype none
module sha256_message_hasher #(
    parameter int unsigned QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_kind,
    input  wire logic [7:0]   s_data_byte,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic              m_status,
    output logic [2:0]        m_word_index,
    output logic [31:0]       m_digest_word,
    output logic              m_last
);
    sha_pkg::q_entry_t push_data, head_data;
    logic              push, pop, full, not_empty;

    sha_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_data_byte (s_data_byte),
        .q_push      (push),
        .q_data      (push_data),
        .q_full      (full)
    );

    sha_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .din       (push_data),
        .full      (full),
        .pop       (pop),
        .dout      (head_data),
        .not_empty (not_empty)
    );

    sha_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (not_empty),
        .q_data        (head_data),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_word_index  (m_word_index),
        .m_digest_word (m_digest_word),
        .m_last        (m_last)
    );
endmodule
`default_nettype wire

[test/tb_sha256_message_hasher.sv]
// Self-checking testbench for the byte-serial SHA-256 message hasher.
`timescale 1ns / 1ps
module tb_sha256_message_hasher;
    localparam bit KIND_BYTE   = 1'b0;
    localparam bit KIND_FINISH = 1'b1;
    localparam bit ST_OK       = 1'b0;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;
    localparam int RANDOM_ITEMS = 384;

    typedef struct {
        bit        status;
        bit [2:0]  idx;
        bit [31:0] word;
        bit        last;
    } digest_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_status;
    logic [2:0]  m_word_index;
    logic [31:0] m_digest_word;
    logic        m_last;

    sha256_message_hasher uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_word_index(m_word_index), .m_digest_word(m_digest_word), .m_last(m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    digest_item_t digest_q[$];
    bit [7:0]     msg_bytes[$];
    bit [31:0]    hash_h[8];
    bit [7:0]     blk[64];
    int           errors = 0;
    int           items_sent = 0;
    int           messages_done = 0;
    int           words_seen = 0;
    int           idle_cnt = 0;
    bit           quiet = 1'b0;
    int           hold_req = 0;

    function automatic bit [31:0] ror(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of blk into hash_h.
    function automatic void compress_blk();
        bit [31:0] w[64];
        bit [31:0] a, b, c, d, e, f, g, h, t1, t2;
        bit [31:0] kk[64];
        kk = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                    hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + kk[t] + w[t];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
        hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    endfunction

    // Pad the gathered message, hash it and queue the eight digest words.
    function automatic void predict_digest();
        bit [7:0]  padded[$];
        bit [63:0] nbits;
        digest_item_t d;
        nbits = 64'(msg_bytes.size()) * 8;
        padded = msg_bytes;
        padded.push_back(8'h80);
        while (padded.size() % 64 != 56) padded.push_back(8'h00);
        for (int i = 0; i < 8; i++) padded.push_back(nbits[63 - 8*i -: 8]);
        hash_h = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
                   32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
        for (int base = 0; base < padded.size(); base += 64) begin
            for (int i = 0; i < 64; i++) blk[i] = padded[base + i];
            compress_blk();
        end
        for (int i = 0; i < 8; i++) begin
            d.status = ST_OK;
            d.idx = 3'(i);
            d.word = hash_h[i];
            d.last = (i == 7);
            digest_q.push_back(d);
        end
        msg_bytes.delete();
    endfunction

    task automatic send_item(bit kind, bit [7:0] data);
        s_valid <= 1'b1;
        s_kind <= kind;
        s_data_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (kind == KIND_BYTE) msg_bytes.push_back(data);
        else predict_digest();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) send_item(KIND_BYTE, 8'($urandom));
        send_item(KIND_FINISH, 8'($urandom));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_item(KIND_FINISH, 8'h00);              // empty message
        send_item(KIND_FINISH, 8'hFF);              // empty again, data ignored
        send_item(KIND_BYTE, 8'h61);
        send_item(KIND_BYTE, 8'h62);
        send_item(KIND_BYTE, 8'h63);
        send_item(KIND_FINISH, 8'hA5);              // "abc"
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, 8'h55);
        send_item(KIND_BYTE, 8'hAA);
        send_item(KIND_FINISH, 8'h5A);
        wait_drained();
    endtask

    // Receiver held off while messages keep arriving; the block must stall its input.
    task automatic test_backpressure();
        hold_req = HOLD_CYCLES;
        send_message(70);
        send_message(2);
        send_message(0);
        wait_drained();
    endtask

    // Message lengths around the one- and two-block padding boundaries.
    task automatic test_padding_edges();
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
        wait_drained();
    endtask

    task automatic test_random();
        int len;
        while (items_sent < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 130) : $urandom_range(0, 20);
            if (len > RANDOM_ITEMS - 1 - items_sent) len = RANDOM_ITEMS - 1 - items_sent;
            send_message(len);
        end
        wait_drained();
    endtask

    task automatic test_full_rate();
        quiet = 1'b1;
        send_message(9);
        send_message(1);
        send_message(12);
        wait_drained();
    endtask

    // Result channel: random ready bursts, a long hold on request, none at the end.
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            m_ready <= 1'b0;
            hold_req <= hold_req - 1;
        end else if (idle_cnt > 0) begin
            m_ready <= 1'b0;
            idle_cnt <= idle_cnt - 1;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            m_ready <= 1'b0;
            idle_cnt <= $urandom_range(0, 18);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        digest_item_t d;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (digest_q.size() == 0) begin
                $error("unexpected result: index %0d word %h", m_word_index, m_digest_word);
                errors++;
            end else begin
                d = digest_q.pop_front();
                if (m_status !== d.status) begin
                    $error("status: expected %0d, got %0d", d.status, m_status); errors++;
                end
                if (m_word_index !== d.idx) begin
                    $error("word_index: expected %0d, got %0d", d.idx, m_word_index); errors++;
                end
                if (m_digest_word !== d.word) begin
                    $error("digest_word: expected %h, got %h", d.word, m_digest_word); errors++;
                end
                if (m_last !== d.last) begin
                    $error("last: expected %0d, got %0d", d.last, m_last); errors++;
                end
                if (d.last) messages_done++;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    int stuck = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stuck <= 0;
        else if (aresetn && (s_valid || digest_q.size() != 0)) stuck <= stuck + 1;
        if (stuck >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("tb_sha256_message_hasher: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_padding_edges();
        test_random();
        test_full_rate();
        if (digest_q.size() != 0) begin
            $error("%0d digest words never arrived", digest_q.size());
            errors++;
        end
        $display("covered %0d input items, %0d messages hashed, %0d digest words checked",
                 items_sent, messages_done, words_seen);
        if (errors == 0) $display("tb_sha256_message_hasher: PASS");
        else $display("tb_sha256_message_hasher: FAIL");
        $finish;
    end
endmodule
